@@ design/clsr_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and the shape coverage test of the clipped shape rasterizer.
// No dependencies; imported by the sequencer and the top level.
package clsr_pkg;

  // Action codes carried by an input item
  localparam logic [2:0] ACT_CLEAR = 3'd0;
  localparam logic [2:0] ACT_RECT  = 3'd1;
  localparam logic [2:0] ACT_TRIUP = 3'd2;
  localparam logic [2:0] ACT_TRIDN = 3'd3;
  localparam logic [2:0] ACT_DIAM  = 3'd4;
  localparam logic [2:0] ACT_READ  = 3'd5;

  // Configuration register indexes
  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  localparam logic [6:0] CFG_SIZE_RESET = 7'd64;
  localparam logic [7:0] CLEAR_CHAR     = 8'h2E;

  // Result hand-off from the sequencer to the output register
  typedef struct packed {
    logic load;     // capture a result this cycle
    logic use_mem;  // result carries the memory read data
  } clsr_res_t;

  // Whether pixel (x,y) is covered by the shape anchored at (fx,fy)
  function automatic logic shape_cover(input logic [2:0]         act,
                                       input logic signed [11:0] x,
                                       input logic signed [11:0] y,
                                       input logic signed [11:0] fx,
                                       input logic signed [11:0] fy,
                                       input logic [7:0]         w,
                                       input logic [7:0]         h,
                                       input logic [6:0]         d);
    logic signed [11:0] ws;
    logic signed [11:0] hs;
    logic signed [11:0] ds;
    logic signed [11:0] dx;
    logic signed [11:0] adx;
    logic signed [11:0] ku;
    logic signed [11:0] kd;
    logic signed [11:0] kdd;
    logic signed [11:0] akdd;
    logic               cov;
    ws   = {4'b0, w};
    hs   = {4'b0, h};
    ds   = {5'b0, d};
    dx   = x - fx;
    adx  = (dx < 0) ? -dx : dx;
    ku   = y - fy;
    kd   = fy - y;
    kdd  = ku - ds;
    akdd = (kdd < 0) ? -kdd : kdd;
    case (act)
      ACT_CLEAR: cov = 1'b1;
      ACT_RECT:  cov = (x >= fx) && (x < fx + ws) && (y >= fy) && (y < fy + hs);
      ACT_TRIUP: cov = (ku >= 0) && (ku < hs) && (adx <= ku);
      ACT_TRIDN: cov = (kd >= 0) && (kd < hs) && (adx <= kd);
      ACT_DIAM:  cov = (ku >= 0) && (ku <= (ds + ds)) && (adx <= ds - akdd);
      default:   cov = 1'b0;
    endcase
    return cov;
  endfunction

endpackage

@@ design/clsr_mem.sv @@
`timescale 1ns / 1ps
// Pixel store: single-port synchronous memory, one access per cycle, registered read.
// No package dependencies.
module clsr_mem #(
  parameter int AW    = 12,
  parameter int DEPTH = 4096
) (
  input  logic          clk,
  input  logic          we,
  input  logic          re,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/clsr_seq.sv @@
`timescale 1ns / 1ps
// Item sequencer: takes items, scans the clipped canvas one pixel a cycle and drives
// the pixel store. Depends on clsr_pkg.
module clsr_seq #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int XW         = 7,
  parameter int YW         = 7,
  parameter int AW         = 12
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [2:0]              in_action,
  input  logic signed [8:0]       in_origin_x,
  input  logic signed [8:0]       in_origin_y,
  input  logic [7:0]              in_rect_width,
  input  logic [7:0]              in_shape_height,
  input  logic [6:0]              in_diamond_radius,
  input  logic [7:0]              in_brush,
  input  logic [6:0]              canvas_width,
  input  logic [6:0]              canvas_height,
  input  logic                    out_free,
  output clsr_pkg::clsr_res_t     res,
  output logic                    mem_we,
  output logic                    mem_re,
  output logic [AW-1:0]           mem_addr,
  output logic [7:0]              mem_wdata
);
  import clsr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DRAW = 3'b010,
    ST_RESP = 3'b100
  } seq_state_t;

  seq_state_t        state_r, state_nxt;
  logic [2:0]        act_r;
  logic signed [8:0] fx_r, fy_r;
  logic [7:0]        w_r, h_r, brush_r;
  logic [6:0]        d_r;
  logic [XW-1:0]     effw_r, x_r, x_nxt;
  logic [YW-1:0]     effh_r, y_r, y_nxt;
  logic [AW-1:0]     base_r, base_nxt;
  logic              use_mem_r, use_mem_nxt;

  logic [8:0]        effw9, effh9;
  logic              accept, rd_in_range, canvas_empty, cov, row_end, last_px;
  logic [AW-1:0]     rd_addr;

  // Saturate the size registers to the memory geometry
  assign effw9 = (9'(canvas_width) > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : 9'(canvas_width);
  assign effh9 = (9'(canvas_height) > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : 9'(canvas_height);

  assign in_stall     = (state_r != ST_IDLE);
  assign accept       = in_valid && !in_stall;
  assign canvas_empty = (effw9 == 9'd0) || (effh9 == 9'd0);
  assign rd_in_range  = !in_origin_x[8] && ({1'b0, in_origin_x[7:0]} < effw9) &&
                        !in_origin_y[8] && ({1'b0, in_origin_y[7:0]} < effh9);
  assign rd_addr      = AW'(32'(in_origin_y[7:0]) * MAX_WIDTH + 32'(in_origin_x[7:0]));

  assign cov     = shape_cover(act_r, 12'(x_r), 12'(y_r), 12'(fx_r), 12'(fy_r),
                               w_r, h_r, d_r);
  assign row_end = (x_r == effw_r - XW'(1));
  assign last_px = row_end && (y_r == effh_r - YW'(1));

  // Memory port: reads only at accept, writes only while drawing
  always_comb begin
    mem_re    = accept && (in_action == ACT_READ) && rd_in_range;
    mem_we    = (state_r == ST_DRAW) && cov;
    mem_addr  = (state_r == ST_DRAW) ? AW'(base_r + AW'(x_r)) : rd_addr;
    mem_wdata = (act_r == ACT_CLEAR) ? CLEAR_CHAR : brush_r;
  end

  always_comb begin
    state_nxt   = state_r;
    x_nxt       = x_r;
    y_nxt       = y_r;
    base_nxt    = base_r;
    use_mem_nxt = use_mem_r;
    res.load    = 1'b0;
    res.use_mem = use_mem_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          x_nxt       = '0;
          y_nxt       = '0;
          base_nxt    = '0;
          use_mem_nxt = 1'b0;
          if (in_action == ACT_READ) begin
            use_mem_nxt = rd_in_range;
            state_nxt   = ST_RESP;
          end else if (in_action <= ACT_DIAM && !canvas_empty) begin
            state_nxt = ST_DRAW;
          end else begin
            state_nxt = ST_RESP;
          end
        end
      end
      ST_DRAW: begin
        // advance the scan, row by row
        if (last_px) begin
          state_nxt = ST_RESP;
        end else if (row_end) begin
          x_nxt    = '0;
          y_nxt    = y_r + YW'(1);
          base_nxt = AW'(base_r + AW'(MAX_WIDTH));
        end else begin
          x_nxt = x_r + XW'(1);
        end
      end
      ST_RESP: begin
        // hold the result until the output register is free
        res.load = out_free;
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      use_mem_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      use_mem_r <= use_mem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    base_r <= base_nxt;
    if (accept) begin
      act_r   <= in_action;
      fx_r    <= in_origin_x;
      fy_r    <= in_origin_y;
      w_r     <= in_rect_width;
      h_r     <= in_shape_height;
      d_r     <= in_diamond_radius;
      brush_r <= in_brush;
      effw_r  <= effw9[XW-1:0];
      effh_r  <= effh9[YW-1:0];
    end
  end

endmodule

@@ design/clipped_shape_rasterizer.sv @@
`timescale 1ns / 1ps
// Clipped shape rasterizer: character canvas drawing engine with a one-port pixel store.
// Flow: a read's data is registered in the pixel store and loaded through the response
//   state into the output register; a clear or shape visits every pixel of the clipped
//   canvas at one pixel per cycle via the single store port; other actions skip the scan.
// Throughput: one item in flight; the next is taken once the previous result is staged.
// Reset: size registers go to 64, control clears; the pixel store is not initialised.
module clipped_shape_rasterizer #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  // item channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_action,
  input  logic signed [8:0] in_origin_x,
  input  logic signed [8:0] in_origin_y,
  input  logic [7:0]        in_rect_width,
  input  logic [7:0]        in_shape_height,
  input  logic [6:0]        in_diamond_radius,
  input  logic [7:0]        in_brush,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_read_char,
  output logic              out_read_valid,
  // configuration write channel
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [6:0]        cfg_wdata
);
  import clsr_pkg::*;

  // Geometry of the pixel store: row-major, MAX_WIDTH cells to a row
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // Scan counters must also hold the clipped size itself
  localparam int XW    = $clog2(MAX_WIDTH + 1);
  localparam int YW    = $clog2(MAX_HEIGHT + 1);

  logic [6:0]    canvas_width_r, canvas_height_r;
  clsr_res_t     res;
  logic          out_free;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata, mem_rdata;
  logic          out_valid_r;
  logic [7:0]    read_char_r;
  logic          read_valid_r;

  // Configuration: always ready; the user must write only while the block is idle, which the block does not enforce
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      canvas_width_r  <= CFG_SIZE_RESET;
      canvas_height_r <= CFG_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IDX_WIDTH:  canvas_width_r  <= cfg_wdata;
        CFG_IDX_HEIGHT: canvas_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequencer: accepts items, scans and clips, drives the store
  clsr_seq #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .XW         (XW),
    .YW         (YW),
    .AW         (AW)
  ) u_seq (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_origin_x       (in_origin_x),
    .in_origin_y       (in_origin_y),
    .in_rect_width     (in_rect_width),
    .in_shape_height   (in_shape_height),
    .in_diamond_radius (in_diamond_radius),
    .in_brush          (in_brush),
    .canvas_width      (canvas_width_r),
    .canvas_height     (canvas_height_r),
    .out_free          (out_free),
    .res               (res),
    .mem_we            (mem_we),
    .mem_re            (mem_re),
    .mem_addr          (mem_addr),
    .mem_wdata         (mem_wdata)
  );

  // Pixel store; read data stays put until the next read, so the result stage
  // may pick it up late when the output is stalled
  clsr_mem #(
    .AW    (AW),
    .DEPTH (DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Output register: free when empty or when its result transfers this cycle
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      read_char_r  <= res.use_mem ? mem_rdata : 8'd0;
      read_valid_r <= res.use_mem;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_char  = read_char_r;
  assign out_read_valid = read_valid_r;

endmodule
